// File: hw/rtl/ild_pkg.sv
// Shared types and constants of the x86-64 instruction length decoder.
package ild_pkg;

    // Sizing
    localparam int MAX_RUN       = 256;
    localparam int PENDING_DEPTH = 10;
    localparam int MAX_LEN       = 10;
    localparam int RUN_W         = $clog2(MAX_RUN + 1);
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W         = $clog2(PENDING_DEPTH);
    localparam int LEN_W         = 4;
    localparam int REM_W         = 5;

    // Remaining-bytes value that never limits a decode
    localparam logic [REM_W-1:0] REM_UNLIMITED = 5'd16;

    // Mnemonic class codes
    typedef enum logic [4:0] {
        CLS_DB        = 5'd0,
        CLS_NOP       = 5'd1,
        CLS_INT3      = 5'd2,
        CLS_RET       = 5'd3,
        CLS_RETF      = 5'd4,
        CLS_LEAVE     = 5'd5,
        CLS_HLT       = 5'd6,
        CLS_PUSH      = 5'd7,
        CLS_POP       = 5'd8,
        CLS_CALL      = 5'd9,
        CLS_JMP       = 5'd10,
        CLS_JMP_SHORT = 5'd11,
        CLS_JZ_SHORT  = 5'd12,
        CLS_JNZ_SHORT = 5'd13,
        CLS_ALU       = 5'd14,
        CLS_MOV       = 5'd15,
        CLS_XOR       = 5'd16,
        CLS_FF_UNK    = 5'd17
    } t_cls;

    // Input request
    typedef struct packed {
        logic [7:0]  code_byte;
        logic [63:0] byte_address;
        logic        last_byte;
    } t_in_req;

    // Output request
    typedef struct packed {
        logic [63:0] instr_address;
        logic [3:0]  instr_length;
        logic [4:0]  mnemonic_class;
        logic [63:0] raw_low;
        logic [15:0] raw_high;
        logic        last_in_run;
    } t_out_req;

    // Decode unit result
    typedef struct packed {
        logic             need_more;
        logic [LEN_W-1:0] len;
        t_cls             cls;
    } t_dec_res;

endpackage

// File: hw/rtl/ild_decoder.sv
// Shared length/class decode unit for one instruction window.
module ild_decoder (
    input  logic [7:0]                  i_bytes [ild_pkg::MAX_LEN],
    input  logic [ild_pkg::CNT_W-1:0]   i_avail,
    input  logic [ild_pkg::REM_W-1:0]   i_remain,
    output ild_pkg::t_dec_res           o_res
);
    import ild_pkg::*;

    localparam logic [7:0] OP_NOP      = 8'h90;
    localparam logic [7:0] OP_INT3     = 8'hCC;
    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_RETF     = 8'hCB;
    localparam logic [7:0] OP_LEAVE    = 8'hC9;
    localparam logic [7:0] OP_HLT      = 8'hF4;
    localparam logic [7:0] OP_PUSH_LO  = 8'h50;
    localparam logic [7:0] OP_PUSH_HI  = 8'h57;
    localparam logic [7:0] OP_POP_LO   = 8'h58;
    localparam logic [7:0] OP_POP_HI   = 8'h5F;
    localparam logic [7:0] OP_CALL     = 8'hE8;
    localparam logic [7:0] OP_JMP      = 8'hE9;
    localparam logic [7:0] OP_JMP_S    = 8'hEB;
    localparam logic [7:0] OP_JZ_S     = 8'h74;
    localparam logic [7:0] OP_JNZ_S    = 8'h75;
    localparam logic [7:0] OP_GRP5     = 8'hFF;
    localparam logic [7:0] OP_ALU_I32  = 8'h81;
    localparam logic [7:0] OP_ALU_I8   = 8'h83;
    localparam logic [7:0] OP_MOV_ST   = 8'h89;
    localparam logic [7:0] OP_MOV_LD   = 8'h8B;
    localparam logic [7:0] OP_XOR_ST   = 8'h31;
    localparam logic [7:0] OP_XOR_LD   = 8'h33;
    localparam logic [7:0] OP_MOV_I_LO = 8'hB8;
    localparam logic [7:0] OP_MOV_I_HI = 8'hBF;
    localparam logic [3:0] REX_HI      = 4'h4;

    logic [REM_W-1:0] len;
    logic [REM_W-1:0] avail;
    logic [7:0]       op;
    logic [7:0]       modrm;
    logic             wide;
    logic             need;
    t_cls             cls;
    logic [2:0]       m_reg;
    logic [1:0]       m_mod;
    logic [2:0]       m_rm;

    assign avail = REM_W'(i_avail);
    assign m_reg = modrm[5:3];
    assign m_mod = modrm[7:6];
    assign m_rm  = modrm[2:0];

    // Prefix, opcode table, ModR/M and clamp
    always_comb begin
        need  = 1'b0;
        cls   = CLS_DB;
        len   = REM_W'(1);
        wide  = 1'b0;
        op    = i_bytes[0];
        modrm = i_bytes[1];
        if (i_bytes[0][7:4] == REX_HI && i_remain >= REM_W'(2)) begin
            need  = (avail < REM_W'(2));
            wide  = i_bytes[0][3];
            op    = i_bytes[1];
            modrm = i_bytes[2];
            len   = REM_W'(2);
        end
        unique case (op) inside
            OP_NOP:   cls = CLS_NOP;
            OP_INT3:  cls = CLS_INT3;
            OP_RET:   cls = CLS_RET;
            OP_RETF:  cls = CLS_RETF;
            OP_LEAVE: cls = CLS_LEAVE;
            OP_HLT:   cls = CLS_HLT;
            [OP_PUSH_LO:OP_PUSH_HI]: cls = CLS_PUSH;
            [OP_POP_LO:OP_POP_HI]:   cls = CLS_POP;
            OP_CALL, OP_JMP: begin
                cls = (op == OP_CALL) ? CLS_CALL : CLS_JMP;
                if (i_remain >= len + REM_W'(4)) len = len + REM_W'(4);
            end
            OP_JMP_S, OP_JZ_S, OP_JNZ_S: begin
                cls = (op == OP_JMP_S) ? CLS_JMP_SHORT :
                      (op == OP_JZ_S)  ? CLS_JZ_SHORT  : CLS_JNZ_SHORT;
                if (i_remain > len) len = len + REM_W'(1);
            end
            OP_GRP5: begin
                if (i_remain > len) begin
                    if (avail <= len) need = 1'b1;
                    len = len + REM_W'(1);
                    cls = (m_reg == 3'd2) ? CLS_CALL :
                          (m_reg == 3'd4) ? CLS_JMP  :
                          (m_reg == 3'd6) ? CLS_PUSH : CLS_FF_UNK;
                    if (m_mod == 2'd0 && m_rm == 3'd5) len = len + REM_W'(4);
                    else if (m_mod == 2'd1)            len = len + REM_W'(1);
                    else if (m_mod == 2'd2)            len = len + REM_W'(4);
                    if (m_rm == 3'd4 && m_mod != 2'd3) len = len + REM_W'(1);
                end
            end
            OP_ALU_I32, OP_ALU_I8: begin
                cls = CLS_ALU;
                if (i_remain > len)
                    len = len + ((op == OP_ALU_I32) ? REM_W'(5) : REM_W'(2));
            end
            OP_MOV_ST, OP_MOV_LD: begin
                cls = CLS_MOV;
                if (i_remain > len) len = len + REM_W'(1);
            end
            OP_XOR_ST, OP_XOR_LD: begin
                cls = CLS_XOR;
                if (i_remain > len) len = len + REM_W'(1);
            end
            [OP_MOV_I_LO:OP_MOV_I_HI]: begin
                cls = CLS_MOV;
                len = len + (wide ? REM_W'(8) : REM_W'(4));
            end
            default: ;
        endcase
        // never longer than the bytes left in the run
        if (len > i_remain) len = i_remain;
    end

    assign o_res.need_more = need;
    assign o_res.len       = len[LEN_W-1:0];
    assign o_res.cls       = cls;

endmodule

// File: hw/rtl/x64_instruction_length_decoder.sv
// Top level of the x86-64 instruction length decoder: byte sequencer around one decode unit.
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_req (code_byte, byte_address, last_byte)
//  output  | out       | o_valid / i_ready  | o_req (address, length, class, raw, last)
//
//  A byte is accepted in S_IDLE and decoded in S_DECODE; when it completes an
//  instruction, the registered result waits in S_OUT until taken. At run end each
//  pending instruction is decoded again in S_FLUSH and then held until taken.
//  All of this runs through one shared decode unit; o_ready is low meanwhile.
//  Reset is synchronous, active low; the pending byte buffer is not cleared.
//  A stalled output request holds its payload until i_ready.
module x64_instruction_length_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ild_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output ild_pkg::t_out_req o_req
);
    import ild_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_FLUSH,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [7:0]       r_buf [PENDING_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [RUN_W-1:0] r_run_off;
    logic [63:0]      r_addr;
    logic             r_last;
    t_out_req         r_out;

    logic [RUN_W-1:0] n_run_off;
    logic             n_last;
    logic [7:0]       win [MAX_LEN];
    logic [REM_W-1:0] remain;
    t_dec_res         dec;
    logic [LEN_W-1:0] flen;
    logic [LEN_W-1:0] e_len;
    logic             e_last;
    logic             main_emit;
    t_out_req         n_out;
    logic [7:0]       n_buf [PENDING_DEPTH];

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_req   = r_out;

    // Run length tracking
    assign n_run_off = r_run_off + RUN_W'(1);
    assign n_last    = i_req.last_byte || (n_run_off >= RUN_W'(MAX_RUN));

    // Decode window and shared decode unit
    always_comb begin
        for (int i = 0; i < MAX_LEN; i++) win[i] = r_buf[i];
    end

    assign remain = (r_state == S_FLUSH) ? REM_W'(r_count) : REM_UNLIMITED;

    ild_decoder u_dec (
        .i_bytes  (win),
        .i_avail  (r_count),
        .i_remain (remain),
        .o_res    (dec)
    );

    assign flen      = (dec.len == '0) ? LEN_W'(1) : dec.len;
    assign main_emit = !dec.need_more && (LEN_W'(r_count) >= dec.len);
    assign e_len     = (r_state == S_FLUSH) ? flen : dec.len;
    assign e_last    = (r_state == S_FLUSH) ? (flen >= LEN_W'(r_count)) : r_last;

    // Output request build, bytes past the length forced to zero
    always_comb begin
        n_out                = '0;
        n_out.instr_address  = r_addr;
        n_out.instr_length   = e_len;
        n_out.mnemonic_class = dec.cls;
        n_out.last_in_run    = e_last;
        for (int i = 0; i < 8; i++)
            n_out.raw_low[8*i +: 8] = (LEN_W'(i) < e_len) ? r_buf[i] : 8'h00;
        for (int i = 8; i < MAX_LEN; i++)
            n_out.raw_high[8*(i-8) +: 8] = (LEN_W'(i) < e_len) ? r_buf[i] : 8'h00;
    end

    // Buffer drops the emitted instruction during flush
    always_comb begin
        for (int i = 0; i < PENDING_DEPTH; i++) begin
            logic [IDX_W:0] src;
            src = (IDX_W+1)'(i) + (IDX_W+1)'(flen);
            if (src < (IDX_W+1)'(PENDING_DEPTH)) n_buf[i] = r_buf[src[IDX_W-1:0]];
            else                                 n_buf[i] = r_buf[i];
        end
    end

    // Pending byte buffer
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_buf[r_count[IDX_W-1:0]] <= i_req.code_byte;
        end else if (r_state == S_FLUSH) begin
            r_buf <= n_buf;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_run_off <= '0;
            r_addr    <= '0;
            r_last    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (r_count == '0) r_addr <= i_req.byte_address;
                        r_count   <= r_count + CNT_W'(1);
                        r_last    <= n_last;
                        r_run_off <= n_last ? '0 : n_run_off;
                        r_state   <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (main_emit) begin
                        r_out   <= n_out;
                        r_count <= '0;
                        r_state <= S_OUT;
                    end else if (r_last) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    r_out   <= n_out;
                    r_count <= r_count - CNT_W'(flen);
                    r_addr  <= r_addr + 64'(flen);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= (r_count != '0) ? S_FLUSH : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/ild_checker.sv
// Port-level checks for the instruction length decoder, bound to the top level.
module ild_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input ild_pkg::t_out_req o_req
);
    import ild_pkg::*;

    // Stalled output request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_req))
        else $error("output request changed while stalled");

    // Input is never taken while a result is shown
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while output valid");

    // A taken byte is decoded before the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

    // Length is always in range
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_req.instr_length != 4'd0) && (o_req.instr_length <= 4'd10))
        else $error("instruction length out of range");

    // Short instructions carry no high bytes
    a_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_req.instr_length <= 4'd8) |-> (o_req.raw_high == 16'h0000))
        else $error("raw bytes past length not zero");

endmodule

bind x64_instruction_length_decoder ild_checker u_ild_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_req   (o_req)
);

// File: sim/x64_instruction_length_decoder_test.sv
// Self-checking testbench of the x86-64 instruction length decoder: byte runs in, instructions out.
module x64_instruction_length_decoder_test;
    import ild_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no request moved on either side
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off of the pressure test
    localparam int DRAIN_CYCLES = 20;   // quiet cycles after the last result

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    t_in_req     in_req;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready;
    t_out_req    out_req;

    // Stimulus shaping
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count;
    int unsigned hold_end;
    int unsigned stall_count;
    int unsigned error_count;

    // Predictor state: bytes of the instruction being assembled
    logic [7:0]  pend_bytes [PENDING_DEPTH];
    int unsigned pend_count;
    int unsigned run_bytes;
    logic [63:0] pend_start;

    t_out_req    expected_instrs [$];

    x64_instruction_length_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_req   (in_req),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_req   (out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Queue helpers: append at the tail
    function automatic void add_byte(ref logic [7:0] run_q[$], input logic [7:0] b);
        run_q.insert(run_q.size(), b);
    endfunction

    function automatic void add_expected(input t_out_req instr);
        expected_instrs.insert(expected_instrs.size(), instr);
    endfunction

    // Length of the instruction at pend_bytes[off], avail bytes present, r bytes left in the run.
    // Zero means a byte needed for the decision has not arrived yet.
    function automatic int unsigned decode_length(input int unsigned off, input int unsigned avail,
                                                  input int unsigned r, output t_cls cls);
        int unsigned len;
        logic [7:0]  op;
        logic [7:0]  modrm;
        logic        wide;
        logic [2:0]  modrm_reg;
        logic [2:0]  modrm_rm;
        logic [1:0]  modrm_mod;
        len = 1;
        op = pend_bytes[off];
        wide = 1'b0;
        cls = CLS_DB;
        // REX prefix only when the opcode can follow it
        if (op[7:4] == 4'h4 && r >= 2) begin
            if (avail < 2) return 0;
            wide = op[3];
            op = pend_bytes[off + 1];
            len = 2;
        end
        casez (op)
            8'h90: cls = CLS_NOP;
            8'hCC: cls = CLS_INT3;
            8'hC3: cls = CLS_RET;
            8'hCB: cls = CLS_RETF;
            8'hC9: cls = CLS_LEAVE;
            8'hF4: cls = CLS_HLT;
            8'b0101_0???: cls = CLS_PUSH;
            8'b0101_1???: cls = CLS_POP;
            8'hE8: begin
                cls = CLS_CALL;
                if (r >= len + 4) len += 4;
            end
            8'hE9: begin
                cls = CLS_JMP;
                if (r >= len + 4) len += 4;
            end
            8'hEB: begin
                cls = CLS_JMP_SHORT;
                if (r > len) len += 1;
            end
            8'h74: begin
                cls = CLS_JZ_SHORT;
                if (r > len) len += 1;
            end
            8'h75: begin
                cls = CLS_JNZ_SHORT;
                if (r > len) len += 1;
            end
            8'hFF: begin
                if (r > len) begin
                    if (avail <= len) return 0;
                    modrm = pend_bytes[off + len];
                    len += 1;
                    modrm_reg = modrm[5:3];
                    modrm_mod = modrm[7:6];
                    modrm_rm = modrm[2:0];
                    case (modrm_reg)
                        3'd2:    cls = CLS_CALL;
                        3'd4:    cls = CLS_JMP;
                        3'd6:    cls = CLS_PUSH;
                        default: cls = CLS_FF_UNK;
                    endcase
                    if (modrm_mod == 2'd0 && modrm_rm == 3'd5) len += 4;
                    else if (modrm_mod == 2'd1) len += 1;
                    else if (modrm_mod == 2'd2) len += 4;
                    if (modrm_rm == 3'd4 && modrm_mod != 2'd3) len += 1;
                end
            end
            8'h81, 8'h83: begin
                cls = CLS_ALU;
                if (r > len) len += (op == 8'h81) ? 5 : 2;
            end
            8'h89, 8'h8B: begin
                cls = CLS_MOV;
                if (r > len) len += 1;
            end
            8'h31, 8'h33: begin
                cls = CLS_XOR;
                if (r > len) len += 1;
            end
            8'b1011_1???: begin
                cls = CLS_MOV;
                len += wide ? 8 : 4;
            end
            default: ;
        endcase
        if (len > r) len = r;
        return len;
    endfunction

    function automatic t_out_req make_instr(input int unsigned off, input int unsigned len,
                                            input t_cls cls, input logic last);
        t_out_req instr;
        instr = '0;
        instr.instr_address = pend_start + 64'(off);
        instr.instr_length = 4'(len);
        instr.mnemonic_class = cls;
        instr.last_in_run = last;
        for (int unsigned i = 0; i < len && off + i < PENDING_DEPTH; i++) begin
            if (i < 8) instr.raw_low[8*i +: 8] = pend_bytes[off + i];
            else instr.raw_high[8*(i-8) +: 8] = pend_bytes[off + i];
        end
        return instr;
    endfunction

    // Expected instructions caused by one accepted code byte
    function automatic void predict_instrs(input t_in_req req);
        int unsigned len;
        int unsigned off;
        int unsigned rem;
        int unsigned n;
        t_cls        cls;
        logic        last;
        n = 0;
        if (pend_count >= PENDING_DEPTH) pend_count = 0;
        if (pend_count == 0) pend_start = req.byte_address;
        pend_bytes[pend_count] = req.code_byte;
        pend_count++;
        run_bytes++;
        last = req.last_byte || run_bytes >= MAX_RUN;

        len = decode_length(0, pend_count, REM_UNLIMITED, cls);
        if (len != 0 && pend_count >= len) begin
            add_expected(make_instr(0, len, cls, last));
            n++;
            pend_count = 0;
        end

        // Run end: decode leftovers again with the run limited to what remains
        if (last) begin
            off = 0;
            while (off < pend_count && n < MAX_LEN) begin
                rem = pend_count - off;
                len = decode_length(off, rem, rem, cls);
                if (len == 0) len = 1;
                add_expected(make_instr(off, len, cls, off + len >= pend_count));
                n++;
                off += len;
            end
            pend_count = 0;
            run_bytes = 0;
        end
    endfunction

    // Offer one code byte, wait for acceptance, then predict
    task automatic send_byte(input t_in_req req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        predict_instrs(req);
    endtask

    // Send a byte run from base upward; scatter puts random addresses on a few bytes
    task automatic send_run(input logic [7:0] run_q[$], input logic [63:0] base,
                            input bit scatter, input bit close_run);
        t_in_req req;
        foreach (run_q[i]) begin
            req.code_byte = run_q[i];
            req.byte_address = base + 64'(i);
            if (scatter && $urandom_range(0, 9) == 0)
                req.byte_address = {$urandom, $urandom};
            req.last_byte = close_run && (i == run_q.size() - 1);
            send_byte(req);
        end
    endtask

    // Append one instruction of the decoded subset with random operand bytes
    function automatic void add_instr(ref logic [7:0] run_q[$]);
        logic [7:0]  rex;
        logic [7:0]  modrm;
        logic        has_rex;
        int unsigned extra;
        extra = 0;
        has_rex = ($urandom_range(0, 4) == 0);
        rex = 8'h40 | 8'($urandom_range(0, 15));
        if (has_rex) add_byte(run_q, rex);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 6))
                    0: add_byte(run_q, 8'h90);
                    1: add_byte(run_q, 8'hCC);
                    2: add_byte(run_q, 8'hC3);
                    3: add_byte(run_q, 8'hCB);
                    4: add_byte(run_q, 8'hC9);
                    5: add_byte(run_q, 8'hF4);
                    default: add_byte(run_q, 8'h50 | 8'($urandom_range(0, 15)));
                endcase
            end
            1: begin
                add_byte(run_q, $urandom_range(0, 1) ? 8'hE8 : 8'hE9);
                extra = 4;
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: add_byte(run_q, 8'hEB);
                    1: add_byte(run_q, 8'h74);
                    default: add_byte(run_q, 8'h75);
                endcase
                extra = 1;
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: add_byte(run_q, 8'h89);
                    1: add_byte(run_q, 8'h8B);
                    2: add_byte(run_q, 8'h31);
                    default: add_byte(run_q, 8'h33);
                endcase
                extra = 1;
            end
            4: begin
                if ($urandom_range(0, 1)) begin
                    add_byte(run_q, 8'h81);
                    extra = 5;
                end else begin
                    add_byte(run_q, 8'h83);
                    extra = 2;
                end
            end
            5, 6: begin
                // ModR/M form: displacement and SIB follow from mod and rm
                modrm = 8'($urandom_range(0, 255));
                add_byte(run_q, 8'hFF);
                add_byte(run_q, modrm);
                if (modrm[7:6] == 2'd0 && modrm[2:0] == 3'd5) extra = 4;
                else if (modrm[7:6] == 2'd1) extra = 1;
                else if (modrm[7:6] == 2'd2) extra = 4;
                if (modrm[2:0] == 3'd4 && modrm[7:6] != 2'd3) extra += 1;
            end
            7, 8: begin
                add_byte(run_q, 8'hB8 | 8'($urandom_range(0, 7)));
                extra = (has_rex && rex[3]) ? 8 : 4;
            end
            default: add_byte(run_q, 8'($urandom_range(0, 255)));
        endcase
        repeat (extra) add_byte(run_q, 8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [63:0] pick_base();
        case ($urandom_range(0, 3))
            0: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 8));
            1: return 64'($urandom_range(0, 64));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Extremes, a sample of opcode classes, truncation at run end, lone prefix
    task automatic test_directed();
        send_run('{8'h4F}, 64'h0, 1'b0, 1'b1);
        send_run('{8'h48, 8'hB8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
                 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
        send_run('{8'hE8, 8'h11, 8'h22}, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
        send_run('{8'hFF, 8'h24, 8'h25}, 64'h0000_0000_0000_1000, 1'b0, 1'b1);
        send_run('{8'h83, 8'hC0}, 64'h8000_0000_0000_0000, 1'b0, 1'b1);
        send_run('{8'h06}, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
        send_run('{8'h31, 8'hC0}, 64'h0, 1'b0, 1'b1);
    endtask

    // Mostly well-formed runs, some cut short at the end, some pure noise
    task automatic test_random(input int unsigned n_bytes);
        logic [7:0]  run_q[$];
        int unsigned sent;
        int unsigned cut;
        int unsigned kind;
        sent = 0;
        while (sent < n_bytes) begin
            run_q.delete();
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 12)) add_byte(run_q, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) add_instr(run_q);
                if (kind <= 3 && run_q.size() > 1) begin
                    cut = $urandom_range(1, (run_q.size() > 3) ? 3 : run_q.size() - 1);
                    repeat (cut) void'(run_q.pop_back());
                end
            end
            send_run(run_q, pick_base(), $urandom_range(0, 4) == 0, 1'b1);
            sent += run_q.size();
        end
    endtask

    // Receiver holds off while the sender keeps offering single-byte instructions
    task automatic test_backpressure();
        logic [7:0] run_q[$];
        repeat (30) add_byte(run_q, 8'h90);
        hold_end = cycle_count + HOLD_CYCLES;
        send_run(run_q, pick_base(), 1'b0, 1'b1);
    endtask

    // Receiver side: output check, ready pattern, watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_instrs.size() == 0) begin
                report_mismatch($sformatf("unexpected instruction at %h", out_req.instr_address));
            end else begin
                if (out_req.instr_address !== expected_instrs[0].instr_address)
                    report_mismatch($sformatf("address %h, expected %h", out_req.instr_address,
                                              expected_instrs[0].instr_address));
                if (out_req.instr_length !== expected_instrs[0].instr_length)
                    report_mismatch($sformatf("length %0d, expected %0d", out_req.instr_length,
                                              expected_instrs[0].instr_length));
                if (out_req.mnemonic_class !== expected_instrs[0].mnemonic_class)
                    report_mismatch($sformatf("class %0d, expected %0d", out_req.mnemonic_class,
                                              expected_instrs[0].mnemonic_class));
                if (out_req.raw_low !== expected_instrs[0].raw_low)
                    report_mismatch($sformatf("raw low %h, expected %h", out_req.raw_low,
                                              expected_instrs[0].raw_low));
                if (out_req.raw_high !== expected_instrs[0].raw_high)
                    report_mismatch($sformatf("raw high %h, expected %h", out_req.raw_high,
                                              expected_instrs[0].raw_high));
                if (out_req.last_in_run !== expected_instrs[0].last_in_run)
                    report_mismatch($sformatf("last flag %b, expected %b", out_req.last_in_run,
                                              expected_instrs[0].last_in_run));
                void'(expected_instrs.pop_front());
            end
        end

        if (cycle_count < hold_end) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        out_ready = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 86;
        cycle_count = 0;
        hold_end = 0;
        stall_count = 0;
        error_count = 0;
        pend_count = 0;
        run_bytes = 0;
        pend_start = '0;
        foreach (pend_bytes[i]) pend_bytes[i] = 8'h00;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(20);

        send_idle_pct = 86;
        recv_idle_pct = 31;
        test_random(20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(20);

        in_valid <= 1'b0;
        while (expected_instrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
